### design/cvg_pkg.sv
// Shared types, constants, step table and arithmetic helpers for the circle vertex generator.
`timescale 1ns / 1ps
`default_nettype none

package cvg_pkg;

    // Field and datapath widths.
    localparam int RADIUS_W    = 16;
    localparam int SEG_W       = 7;
    localparam int IDX_W       = 6;
    localparam int POS_W       = 18;
    localparam int ACC_W       = 26;
    localparam int TRIG_W      = 18;
    localparam int PROD_W      = ACC_W + TRIG_W;
    localparam int SEG_MUL_W   = 20;
    localparam int QUEUE_DEPTH = 2;

    // Step table: one entry per segment count 0 to 64, each {sine, cosine} in Q2.16.
    localparam int TABLE_DEPTH = 65;
    localparam int ENTRY_W     = 2 * TRIG_W;
    localparam int TABLE_BITS  = TABLE_DEPTH * ENTRY_W;

    // 2*pi in Q30.
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    // One queued circle: its radius and its clamped segment count.
    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [SEG_W-1:0]    seg;
    } job_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EMIT,
        BK_ROTATE
    } back_state_t;

    // Round a Q30 sum to Q16: magnitude rounded half up, sign restored.
    function automatic logic signed [TRIG_W-1:0] q30_to_q16(input longint v);
        longint unsigned mag;
        longint          res;
        begin
            if (v < 0)
            begin
                mag = longint'(-v);
                res = -longint'((mag + 64'd8192) >> 14);
            end
            else
            begin
                mag = longint'(v);
                res = longint'((mag + 64'd8192) >> 14);
            end
            q30_to_q16 = res[TRIG_W-1:0];
        end
    endfunction

    // Build the whole sine/cosine table at elaboration: fixed entries for counts up to 2, a Taylor series in Q30 above.
    function automatic logic [TABLE_BITS-1:0] build_step_table();
        logic [TABLE_BITS-1:0]  tbl;
        longint unsigned        t;
        longint unsigned        u;
        longint                 cs;
        longint                 sn;
        logic signed [TRIG_W-1:0] s_q16;
        logic signed [TRIG_W-1:0] c_q16;
        begin
            tbl = '0;
            for (int n = 0; n < TABLE_DEPTH; n++)
            begin
                if (n <= 1)
                begin
                    s_q16 = '0;
                    c_q16 = 18'sd65536;
                end
                else if (n == 2)
                begin
                    s_q16 = '0;
                    c_q16 = -18'sd65536;
                end
                else
                begin
                    t  = TWO_PI_Q30 / 64'(n);
                    u  = 64'd1 << 30;
                    cs = longint'(u);
                    sn = 0;
                    for (int j = 1; j <= 24; j++)
                    begin
                        u = ((u * t) >> 30) / 64'(j);
                        case (j % 4)
                            0:       cs = cs + longint'(u);
                            1:       sn = sn + longint'(u);
                            2:       cs = cs - longint'(u);
                            default: sn = sn - longint'(u);
                        endcase
                    end
                    s_q16 = q30_to_q16(sn);
                    c_q16 = q30_to_q16(cs);
                end
                tbl[n*ENTRY_W +: ENTRY_W] = {s_q16, c_q16};
            end
            build_step_table = tbl;
        end
    endfunction

    localparam logic [TABLE_BITS-1:0] STEP_TABLE = build_step_table();

    // Saturate a 29-bit Q13.16 sum back to the Q10.16 accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+2:0] v);
        begin
            if (v[ACC_W+2:ACC_W-1] == 4'b0000 || v[ACC_W+2:ACC_W-1] == 4'b1111)
            begin
                sat_acc = v[ACC_W-1:0];
            end
            else if (v[ACC_W+2])
            begin
                sat_acc = {1'b1, {(ACC_W-1){1'b0}}};
            end
            else
            begin
                sat_acc = {1'b0, {(ACC_W-1){1'b1}}};
            end
        end
    endfunction

    // Round the accumulator to Q.6, add the radius and saturate to the position range.
    function automatic logic signed [POS_W-1:0] vertex_pos(
        input logic signed [ACC_W-1:0] acc,
        input logic [RADIUS_W-1:0]     rad
    );
        logic signed [ACC_W:0]   rnd;
        logic signed [POS_W:0]   sum;
        begin
            rnd = {acc[ACC_W-1], acc} + (ACC_W+1)'(512);
            sum = {{2{rnd[ACC_W]}}, rnd[ACC_W:10]} + {3'b000, rad};
            if (sum[POS_W] == sum[POS_W-1])
            begin
                vertex_pos = sum[POS_W-1:0];
            end
            else if (sum[POS_W])
            begin
                vertex_pos = {1'b1, {(POS_W-1){1'b0}}};
            end
            else
            begin
                vertex_pos = {1'b0, {(POS_W-1){1'b1}}};
            end
        end
    endfunction

endpackage

`default_nettype wire

### design/cvg_front.sv
// Front end: takes radius beats, works out the clamped segment count and queues nonempty circles.
`timescale 1ns / 1ps
`default_nettype none

module cvg_front #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          radius_valid,
    output logic                               radius_ready,
    input  wire logic [cvg_pkg::RADIUS_W-1:0]  radius,
    output logic                               job_valid,
    input  wire logic                          job_ready,
    output cvg_pkg::job_t                      job
);

    localparam logic [cvg_pkg::SEG_MUL_W-1:0] SEG_LIMIT =
        cvg_pkg::SEG_MUL_W'(MAX_SEGMENTS * 80);
    localparam logic [cvg_pkg::SEG_W-1:0] SEG_MAX = cvg_pkg::SEG_W'(MAX_SEGMENTS);

    logic                         hold_valid_reg;
    logic                         hold_valid_next;
    logic [cvg_pkg::RADIUS_W-1:0] hold_radius_reg;
    logic [cvg_pkg::SEG_MUL_W-1:0] scaled;
    logic [27:0]                  recip_prod;
    logic [cvg_pkg::SEG_W-1:0]    seg;
    logic                         seg_zero;
    logic                         leave;

    // Segment count floor(r * 9 / 80); below the clamp the quotient comes from 1/80 in Q20.
    always_comb
    begin
        scaled     = {1'b0, hold_radius_reg, 3'b000} + {4'b0000, hold_radius_reg};
        recip_prod = 28'(scaled[12:0]) * 28'd13108;
        if (scaled >= SEG_LIMIT)
        begin
            seg = SEG_MAX;
        end
        else
        begin
            seg = recip_prod[26:20];
        end
    end

    // A held radius leaves when queued, or at once when it draws no vertices.
    assign seg_zero     = (seg == '0);
    assign job_valid    = hold_valid_reg && !seg_zero;
    assign leave        = hold_valid_reg && (seg_zero || job_ready);
    assign radius_ready = !hold_valid_reg || leave;
    assign job          = {hold_radius_reg, seg};

    always_comb
    begin
        if (radius_valid && radius_ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (leave)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (radius_valid && radius_ready)
        begin
            hold_radius_reg <= radius;
        end
    end

endmodule

`default_nettype wire

### design/cvg_queue.sv
// Short queue of circle jobs between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module cvg_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire cvg_pkg::job_t  push_job,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output cvg_pkg::job_t       pop_job
);

    localparam int PTR_W = $clog2(cvg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cvg_pkg::QUEUE_DEPTH + 1);

    cvg_pkg::job_t     slots [cvg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(cvg_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(cvg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(cvg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### design/cvg_back.sv
// Back end: rotates the point once per vertex and drives the vertex output register.
`timescale 1ns / 1ps
`default_nettype none

module cvg_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              job_valid,
    output logic                                   job_ready,
    input  wire cvg_pkg::job_t                     job,
    output logic                                   vertex_valid,
    input  wire logic                              vertex_ready,
    output logic [cvg_pkg::IDX_W-1:0]              vertex_index,
    output logic signed [cvg_pkg::POS_W-1:0]       pos_x,
    output logic signed [cvg_pkg::POS_W-1:0]       pos_y,
    output logic                                   last
);

    cvg_pkg::back_state_t state_reg;
    cvg_pkg::back_state_t state_next;

    // Circle in progress.
    logic [cvg_pkg::RADIUS_W-1:0]       radius_hold_reg;
    logic [cvg_pkg::SEG_W-1:0]          seg_reg;
    logic [cvg_pkg::IDX_W-1:0]          idx_reg;
    logic signed [cvg_pkg::TRIG_W-1:0]  step_sine_reg;
    logic signed [cvg_pkg::TRIG_W-1:0]  step_cosine_reg;
    logic signed [cvg_pkg::ACC_W-1:0]   x_accum_reg;
    logic signed [cvg_pkg::ACC_W-1:0]   y_accum_reg;

    // Rotation products, registered between the multiply and the sum.
    logic signed [cvg_pkg::PROD_W-1:0]  cx_reg;
    logic signed [cvg_pkg::PROD_W-1:0]  sy_reg;
    logic signed [cvg_pkg::PROD_W-1:0]  sx_reg;
    logic signed [cvg_pkg::PROD_W-1:0]  cy_reg;

    // Output register.
    logic                               vertex_valid_reg;
    logic                               vertex_valid_next;
    logic [cvg_pkg::IDX_W-1:0]          vertex_index_reg;
    logic signed [cvg_pkg::POS_W-1:0]   pos_x_reg;
    logic signed [cvg_pkg::POS_W-1:0]   pos_y_reg;
    logic                               last_reg;

    logic                               out_free;
    logic                               load_job;
    logic                               emit;
    logic                               rotate;
    logic                               is_last;
    logic [cvg_pkg::ENTRY_W-1:0]        entry;
    logic signed [cvg_pkg::ACC_W-1:0]   x_start;
    logic signed [cvg_pkg::PROD_W:0]    sum_x;
    logic signed [cvg_pkg::PROD_W:0]    sum_y;
    logic signed [cvg_pkg::ACC_W+2:0]   x_round;
    logic signed [cvg_pkg::ACC_W+2:0]   y_round;

    assign out_free = !vertex_valid_reg || vertex_ready;
    assign is_last  = (({1'b0, idx_reg} + 7'd1) == seg_reg);

    // Next state.
    always_comb
    begin
        case (state_reg)
            cvg_pkg::BK_IDLE:
                state_next = job_valid ? cvg_pkg::BK_EMIT : cvg_pkg::BK_IDLE;
            cvg_pkg::BK_EMIT:
                state_next = out_free ? cvg_pkg::BK_ROTATE : cvg_pkg::BK_EMIT;
            cvg_pkg::BK_ROTATE:
                state_next = is_last ? cvg_pkg::BK_IDLE : cvg_pkg::BK_EMIT;
            default:
                state_next = cvg_pkg::BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        job_ready = 1'b0;
        emit      = 1'b0;
        rotate    = 1'b0;
        case (state_reg)
            cvg_pkg::BK_IDLE:   job_ready = 1'b1;
            cvg_pkg::BK_EMIT:   emit      = out_free;
            cvg_pkg::BK_ROTATE: rotate    = 1'b1;
            default:            job_ready = 1'b0;
        endcase
    end

    assign load_job = job_ready && job_valid;

    // Table lookup and start point (r, 0), saturated for radii of 512 pixels and up.
    assign entry   = cvg_pkg::STEP_TABLE[32'(job.seg) * cvg_pkg::ENTRY_W +: cvg_pkg::ENTRY_W];
    assign x_start = job.radius[cvg_pkg::RADIUS_W-1] ? {1'b0, {(cvg_pkg::ACC_W-1){1'b1}}}
                                                     : {job.radius, 10'b0};

    // Sum the products and round half up at bit 16; sat_acc saturates the result when it is stored.
    always_comb
    begin
        sum_x   = {cx_reg[cvg_pkg::PROD_W-1], cx_reg} - {sy_reg[cvg_pkg::PROD_W-1], sy_reg}
                  + (cvg_pkg::PROD_W+1)'(32768);
        sum_y   = {sx_reg[cvg_pkg::PROD_W-1], sx_reg} + {cy_reg[cvg_pkg::PROD_W-1], cy_reg}
                  + (cvg_pkg::PROD_W+1)'(32768);
        x_round = sum_x[cvg_pkg::PROD_W:16];
        y_round = sum_y[cvg_pkg::PROD_W:16];
    end

    always_comb
    begin
        if (emit)
        begin
            vertex_valid_next = 1'b1;
        end
        else if (vertex_ready)
        begin
            vertex_valid_next = 1'b0;
        end
        else
        begin
            vertex_valid_next = vertex_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cvg_pkg::BK_IDLE;
            vertex_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            vertex_valid_reg <= vertex_valid_next;
        end
    end

    // Circle state: loaded from the queue, advanced once per vertex.
    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            radius_hold_reg <= job.radius;
            seg_reg         <= job.seg;
            idx_reg         <= '0;
            step_sine_reg   <= entry[cvg_pkg::ENTRY_W-1:cvg_pkg::TRIG_W];
            step_cosine_reg <= entry[cvg_pkg::TRIG_W-1:0];
            x_accum_reg     <= x_start;
            y_accum_reg     <= '0;
        end
        else if (rotate)
        begin
            idx_reg     <= idx_reg + 1'b1;
            x_accum_reg <= cvg_pkg::sat_acc(x_round);
            y_accum_reg <= cvg_pkg::sat_acc(y_round);
        end
    end

    // Vertex beat and rotation products are both taken from the current point.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            vertex_index_reg <= idx_reg;
            pos_x_reg        <= cvg_pkg::vertex_pos(x_accum_reg, radius_hold_reg);
            pos_y_reg        <= cvg_pkg::vertex_pos(y_accum_reg, radius_hold_reg);
            last_reg         <= is_last;
            cx_reg           <= step_cosine_reg * x_accum_reg;
            sy_reg           <= step_sine_reg * y_accum_reg;
            sx_reg           <= step_sine_reg * x_accum_reg;
            cy_reg           <= step_cosine_reg * y_accum_reg;
        end
    end

    assign vertex_valid = vertex_valid_reg;
    assign vertex_index = vertex_index_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

### design/circle_vertex_generator.sv
// Top level of the circle vertex generator: front end, job queue and rotation back end.
`timescale 1ns / 1ps
`default_nettype none

// Each radius beat (unsigned Q10.6) yields floor(radius * 7.2) vertices, clamped to
// MAX_SEGMENTS, as a closed polygon loop starting at (2r, r) and turning counterclockwise;
// each vertex beat carries its index, the position in signed Q12.6 offset by (r, r) and
// saturated, and a last flag on the final vertex. A radius below 9 raw units produces no
// beats. Per vertex the back end passes through EMIT, which registers the vertex beat
// and the multiplier products and waits while the output register is full, then ROTATE,
// the rounding and saturating add of the rotation recurrence. The front end takes a new
// radius every cycle unless a held radius waits on a full two-deep queue, so up to three
// radii can wait behind the circle being drawn; zero-segment radii skip the queue.
module circle_vertex_generator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              radius_valid,
    output logic                                   radius_ready,
    input  wire logic [cvg_pkg::RADIUS_W-1:0]      radius,
    output logic                                   vertex_valid,
    input  wire logic                              vertex_ready,
    output logic [cvg_pkg::IDX_W-1:0]              vertex_index,
    output logic signed [cvg_pkg::POS_W-1:0]       pos_x,
    output logic signed [cvg_pkg::POS_W-1:0]       pos_y,
    output logic                                   last
);

    logic           front_valid;
    logic           front_ready;
    cvg_pkg::job_t  front_job;
    logic           back_valid;
    logic           back_ready;
    cvg_pkg::job_t  back_job;

    cvg_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .radius_valid (radius_valid),
        .radius_ready (radius_ready),
        .radius       (radius),
        .job_valid    (front_valid),
        .job_ready    (front_ready),
        .job          (front_job)
    );

    cvg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    cvg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (back_valid),
        .job_ready    (back_ready),
        .job          (back_job),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .last         (last)
    );

endmodule

`default_nettype wire

### verif/tb_circle_vertex_generator.sv
// Self-checking testbench for the circle vertex generator with its own rotation predictor.
`timescale 1ns / 1ps

module tb_circle_vertex_generator;

    localparam int     SEG_LIMIT    = 64;
    localparam int     RANDOM_BEATS = 140;
    localparam int     HOLD_CYCLES  = 500;
    localparam int     DRAIN_CYCLES = 300;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam longint ACC_HI       = 64'sd33554431;
    localparam longint ACC_LO       = -64'sd33554432;
    localparam longint POS_HI       = 64'sd131071;
    localparam longint POS_LO       = -64'sd131072;

    // One vertex beat as seen on the output port.
    typedef struct packed {
        logic [cvg_pkg::IDX_W-1:0]        index;
        logic signed [cvg_pkg::POS_W-1:0] x;
        logic signed [cvg_pkg::POS_W-1:0] y;
        logic                             last;
    } vertex_t;

    // One directed radius; typed rows carry up to two vertices written out by hand.
    typedef struct packed {
        logic                         typed;
        logic [1:0]                   n_typed;
        vertex_t                      first;
        vertex_t                      second;
        logic [cvg_pkg::RADIUS_W-1:0] radius;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 20;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Zero segments: the smallest radius and the largest one that draws nothing.
        '{1'b1, 2'd0, '0, '0, 16'd0},
        '{1'b1, 2'd0, '0, '0, 16'd8},
        // One segment: the point stays at (r, 0).
        '{1'b1, 2'd1, '{6'd0, 18'sd18, 18'sd9, 1'b1}, '0, 16'd9},
        // Two segments: a half turn flips x.
        '{1'b1, 2'd2, '{6'd0, 18'sd36, 18'sd18, 1'b0}, '{6'd1, 18'sd0, 18'sd18, 1'b1}, 16'd18},
        '{1'b0, 2'd0, '0, '0, 16'd26},
        '{1'b0, 2'd0, '0, '0, 16'd27},
        '{1'b0, 2'd0, '0, '0, 16'd35},
        '{1'b0, 2'd0, '0, '0, 16'd36},
        '{1'b0, 2'd0, '0, '0, 16'd100},
        '{1'b0, 2'd0, '0, '0, 16'd300},
        '{1'b0, 2'd0, '0, '0, 16'd568},
        '{1'b0, 2'd0, '0, '0, 16'd569},
        '{1'b0, 2'd0, '0, '0, 16'd1000},
        // Largest radius whose start point still fits the accumulator, then the first that
        // saturates it.
        '{1'b0, 2'd0, '0, '0, 16'd32767},
        '{1'b0, 2'd0, '0, '0, 16'd32768},
        '{1'b0, 2'd0, '0, '0, 16'h5555},
        '{1'b0, 2'd0, '0, '0, 16'hAAAA},
        '{1'b0, 2'd0, '0, '0, 16'hFFFF},
        '{1'b1, 2'd0, '0, '0, 16'd1},
        '{1'b0, 2'd0, '0, '0, 16'd5000}
    };

    logic                                clk;
    logic                                rst_n        = 1'b0;
    logic                                radius_valid = 1'b0;
    logic                                radius_ready;
    logic [cvg_pkg::RADIUS_W-1:0]        radius       = '0;
    logic                                vertex_valid;
    logic                                vertex_ready = 1'b0;
    logic [cvg_pkg::IDX_W-1:0]           vertex_index;
    logic signed [cvg_pkg::POS_W-1:0]    pos_x;
    logic signed [cvg_pkg::POS_W-1:0]    pos_y;
    logic                                last;

    // Predictor state at the block's own widths.
    logic signed [cvg_pkg::ACC_W-1:0]    acc_x;
    logic signed [cvg_pkg::ACC_W-1:0]    acc_y;
    logic signed [cvg_pkg::TRIG_W-1:0]   step_sin;
    logic signed [cvg_pkg::TRIG_W-1:0]   step_cos;
    logic [cvg_pkg::RADIUS_W-1:0]        held_radius;

    vertex_t                    pending_vertices [$];
    int                         fail_count    = 0;
    int                         cycle_count   = 0;
    int                         send_idle_pct = 37;
    int                         take_idle_pct = 63;
    bit                         hold_req      = 1'b0;

    circle_vertex_generator #(
        .MAX_SEGMENTS (SEG_LIMIT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .radius_valid (radius_valid),
        .radius_ready (radius_ready),
        .radius       (radius),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .last         (last)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q30 to Q16: magnitude rounded half up at bit 14, sign put back afterwards.
    function automatic logic signed [cvg_pkg::TRIG_W-1:0] round_q16(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + 64'sd8192) >>> 14;
        return (v < 0) ? cvg_pkg::TRIG_W'(-mag) : cvg_pkg::TRIG_W'(mag);
    endfunction

    // Sine and cosine of 2*pi/n from a Taylor series in Q30 up to the x^24 term; fixed values for n up to 2.
    function automatic void step_entry(input int unsigned n,
                                       output logic signed [cvg_pkg::TRIG_W-1:0] s,
                                       output logic signed [cvg_pkg::TRIG_W-1:0] c);
        longint unsigned angle;
        longint unsigned term;
        longint          sin_sum;
        longint          cos_sum;
        if (n <= 1)
        begin
            s = '0;
            c = 18'sd65536;
        end
        else if (n == 2)
        begin
            s = '0;
            c = -18'sd65536;
        end
        else
        begin
            angle   = 64'd6746518852 / 64'(n);
            term    = 64'd1 << 30;
            cos_sum = longint'(term);
            sin_sum = 0;
            for (int j = 1; j <= 24; j++)
            begin
                term = ((term * angle) >> 30) / 64'(j);
                case (j % 4)
                    0:       cos_sum = cos_sum + longint'(term);
                    1:       sin_sum = sin_sum + longint'(term);
                    2:       cos_sum = cos_sum - longint'(term);
                    default: sin_sum = sin_sum - longint'(term);
                endcase
            end
            s = round_q16(sin_sum);
            c = round_q16(cos_sum);
        end
    endfunction

    // Walk one circle through the rotation recurrence; optionally queue its vertex beats.
    task automatic trace_circle(input logic [cvg_pkg::RADIUS_W-1:0] r, input bit record);
        int unsigned segs;
        longint      nx;
        longint      ny;
        vertex_t     v;
        segs = (int'(r) * 9) / 80;
        if (segs > SEG_LIMIT)
        begin
            segs = SEG_LIMIT;
        end
        held_radius = r;
        if (segs != 0)
        begin
            step_entry(segs, step_sin, step_cos);
            acc_x = cvg_pkg::ACC_W'(clamp(longint'(r) <<< 10, ACC_LO, ACC_HI));
            acc_y = '0;
            for (int unsigned i = 0; i < segs; i++)
            begin
                v.index = cvg_pkg::IDX_W'(i);
                v.x     = cvg_pkg::POS_W'(clamp(((longint'(acc_x) + 512) >>> 10)
                                                + longint'(held_radius), POS_LO, POS_HI));
                v.y     = cvg_pkg::POS_W'(clamp(((longint'(acc_y) + 512) >>> 10)
                                                + longint'(held_radius), POS_LO, POS_HI));
                v.last  = (i + 1 == segs);
                if (record)
                begin
                    pending_vertices.push_back(v);
                end
                nx = longint'(step_cos) * longint'(acc_x) - longint'(step_sin) * longint'(acc_y);
                ny = longint'(step_sin) * longint'(acc_x) + longint'(step_cos) * longint'(acc_y);
                acc_x = cvg_pkg::ACC_W'(clamp((nx + 32768) >>> 16, ACC_LO, ACC_HI));
                acc_y = cvg_pkg::ACC_W'(clamp((ny + 32768) >>> 16, ACC_LO, ACC_HI));
            end
        end
    endtask

    // Mostly small circles so that segment counts vary; a few from the full range.
    function automatic logic [cvg_pkg::RADIUS_W-1:0] pick_radius();
        int k;
        k = $urandom_range(0, 99);
        if (k < 10)
        begin
            return cvg_pkg::RADIUS_W'($urandom_range(0, 8));
        end
        else if (k < 80)
        begin
            return cvg_pkg::RADIUS_W'($urandom_range(9, 600));
        end
        return cvg_pkg::RADIUS_W'($urandom);
    endfunction

    // Offer one radius beat from a falling edge; returns at the rising edge that takes it.
    task automatic offer_radius(input logic [cvg_pkg::RADIUS_W-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            radius_valid <= 1'b0;
            radius       <= cvg_pkg::RADIUS_W'($urandom);
            @(negedge clk);
        end
        radius_valid <= 1'b1;
        radius       <= r;
        @(posedge clk);
        while (!radius_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off when asked for.
    initial
    begin
        bit hold_done;
        int held;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                vertex_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                begin
                    @(negedge clk);
                end
                hold_done = 1'b1;
            end
            vertex_ready <= ($urandom_range(0, 99) >= take_idle_pct);
        end
    end

    // Compare every accepted vertex beat with the oldest queued prediction.
    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && vertex_valid && vertex_ready)
        begin
            if (pending_vertices.size() == 0)
            begin
                $error("unexpected vertex beat: index %0d x %0d y %0d last %0b",
                       vertex_index, pos_x, pos_y, last);
                fail_count++;
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (vertex_index !== want.index)
                begin
                    $error("vertex_index: expected %0d, actual %0d", want.index, vertex_index);
                    fail_count++;
                end
                if (pos_x !== want.x)
                begin
                    $error("pos_x: expected %0d, actual %0d", want.x, pos_x);
                    fail_count++;
                end
                if (pos_y !== want.y)
                begin
                    $error("pos_y: expected %0d, actual %0d", want.y, pos_y);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Reset, directed circles, then random circles over three back-pressure phases.
    initial
    begin
        stim_row_t row;
        logic [cvg_pkg::RADIUS_W-1:0] r;
        trace_circle('0, 1'b0);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            offer_radius(row.radius);
            if (row.typed)
            begin
                if (row.n_typed > 0)
                begin
                    pending_vertices.push_back(row.first);
                end
                if (row.n_typed > 1)
                begin
                    pending_vertices.push_back(row.second);
                end
                trace_circle(row.radius, 1'b0);
            end
            else
            begin
                trace_circle(row.radius, 1'b1);
            end
            @(negedge clk);
        end

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == 50)
            begin
                send_idle_pct = 63;
                take_idle_pct = 37;
            end
            else if (i == 105)
            begin
                // Sender streams while the receiver holds off, so the queue backs up.
                send_idle_pct = 0;
                take_idle_pct = 0;
                hold_req      = 1'b1;
            end
            r = pick_radius();
            offer_radius(r);
            trace_circle(r, 1'b1);
            @(negedge clk);
        end
        radius_valid <= 1'b0;

        while (pending_vertices.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
